[rtl/core/ctbb_pkg.sv]
// ----------------------------------------------------------------------------
// ctbb_pkg
// Shared types and constants of the color threshold bounding box block.
// ----------------------------------------------------------------------------
package ctbb_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   localparam int CHAN_W = 8;
   localparam int POS_W  = 11;
   localparam int SIZE_W = 12;

   localparam logic [POS_W-1:0] COL_LAST = POS_W'(MAX_WIDTH - 1);
   localparam logic [POS_W-1:0] ROW_LAST = POS_W'(MAX_HEIGHT - 1);

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_MIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_MAX  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_MAX = 2'd2;

   localparam logic [CHAN_W-1:0] RED_MIN_RESET   = 8'd150;
   localparam logic [CHAN_W-1:0] BLUE_MAX_RESET  = 8'd50;
   localparam logic [CHAN_W-1:0] GREEN_MAX_RESET = 8'd50;

   // queue between front and back
   localparam int PIX_Q_DEPTH = 4;
   localparam int PIX_Q_AW    = $clog2(PIX_Q_DEPTH);

   // result buffer
   localparam int RSP_Q_DEPTH = 2;
   localparam int RSP_Q_AW    = $clog2(RSP_Q_DEPTH);

   // classified pixel word
   typedef struct packed {
      logic             match;
      logic             eof;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
   } pix_word_type;

   // frame result word
   typedef struct packed {
      logic              found;
      logic [POS_W-1:0]  left;
      logic [POS_W-1:0]  top;
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
   } box_type;

   // handshake between a producer and a queue
   typedef struct packed {
      logic push;
      logic full;
   } q_ctl_type;

endpackage

[rtl/core/ctbb_front.sv]
// ----------------------------------------------------------------------------
// ctbb_front
// Takes pixels, keeps the raster position and tests the color thresholds.
// ----------------------------------------------------------------------------
module ctbb_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  logic [ctbb_pkg::CHAN_W-1:0]   req_blue,
   input  logic [ctbb_pkg::CHAN_W-1:0]   req_green,
   input  logic [ctbb_pkg::CHAN_W-1:0]   req_red,
   input  logic                          req_end_of_line,
   input  logic                          req_end_of_frame,
   input  logic                          csr_valid,
   input  logic [ctbb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ctbb_pkg::CHAN_W-1:0]   csr_wdata,
   input  logic                          q_full,
   output ctbb_pkg::q_ctl_type           q_ctl,
   output ctbb_pkg::pix_word_type        q_word
);
   import ctbb_pkg::*;

   logic [CHAN_W-1:0] red_min_ff, red_min_in;
   logic [CHAN_W-1:0] blue_max_ff, blue_max_in;
   logic [CHAN_W-1:0] green_max_ff, green_max_in;
   logic [POS_W-1:0]  col_ff, col_in;
   logic [POS_W-1:0]  row_ff, row_in;
   logic              accept;

   assign accept = req_push & ~q_full;

   always_comb begin
      red_min_in   = red_min_ff;
      blue_max_in  = blue_max_ff;
      green_max_in = green_max_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RED_MIN:   red_min_in   = csr_wdata;
            CSR_BLUE_MAX:  blue_max_in  = csr_wdata;
            CSR_GREEN_MAX: green_max_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // raster position; counters saturate at the last column / row
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (req_end_of_frame) begin
            col_in = '0;
            row_in = '0;
         end else if (req_end_of_line) begin
            col_in = '0;
            if (row_ff < ROW_LAST) row_in = row_ff + POS_W'(1);
         end else begin
            if (col_ff < COL_LAST) col_in = col_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_min_ff   <= RED_MIN_RESET;
         blue_max_ff  <= BLUE_MAX_RESET;
         green_max_ff <= GREEN_MAX_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
      end else begin
         red_min_ff   <= red_min_in;
         blue_max_ff  <= blue_max_in;
         green_max_ff <= green_max_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
      end
   end

   assign q_ctl.push   = accept;
   assign q_ctl.full   = q_full;
   assign q_word.match = (req_red > red_min_ff) && (req_blue < blue_max_ff) &&
                         (req_green < green_max_ff);
   assign q_word.eof   = req_end_of_frame;
   assign q_word.col   = col_ff;
   assign q_word.row   = row_ff;

endmodule

[rtl/core/ctbb_pix_queue.sv]
// ----------------------------------------------------------------------------
// ctbb_pix_queue
// Short queue of classified pixel words between front and back.
// ----------------------------------------------------------------------------
module ctbb_pix_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  ctbb_pkg::q_ctl_type    wr_ctl,
   input  ctbb_pkg::pix_word_type wr_word,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output ctbb_pkg::pix_word_type rd_word
);
   import ctbb_pkg::*;

   pix_word_type          mem [PIX_Q_DEPTH];
   logic [PIX_Q_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PIX_Q_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PIX_Q_AW:0]     count_ff, count_in;
   logic                  do_wr, do_rd;

   assign full  = (count_ff == (PIX_Q_AW+1)'(PIX_Q_DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr_ctl.push & ~wr_ctl.full;
   assign do_rd = pop & ~empty;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + PIX_Q_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + PIX_Q_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) count_in = count_ff + (PIX_Q_AW+1)'(1);
      if (!do_wr && do_rd) count_in = count_ff - (PIX_Q_AW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) mem[wr_ptr_ff] <= wr_word;
   end

   assign rd_word = mem[rd_ptr_ff];

endmodule

[rtl/core/ctbb_back.sv]
// ----------------------------------------------------------------------------
// ctbb_back
// Tracks the box of matching pixels and buffers one result per frame.
// ----------------------------------------------------------------------------
module ctbb_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  ctbb_pkg::pix_word_type q_word,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output ctbb_pkg::box_type      rsp_box
);
   import ctbb_pkg::*;

   logic [POS_W-1:0]    lc_ff, lc_in, gc_ff, gc_in;
   logic [POS_W-1:0]    lr_ff, lr_in, gr_ff, gr_in;
   logic                any_ff, any_in;
   logic [POS_W-1:0]    n_lc, n_gc, n_lr, n_gr;
   logic                n_any;
   box_type             box;

   box_type             rq [RSP_Q_DEPTH];
   logic [RSP_Q_AW-1:0] rq_wr_ff, rq_wr_in, rq_rd_ff, rq_rd_in;
   logic [RSP_Q_AW:0]   rq_cnt_ff, rq_cnt_in;
   logic                rq_full, rq_push, rq_pop;

   assign rq_full   = (rq_cnt_ff == (RSP_Q_AW+1)'(RSP_Q_DEPTH));
   assign rsp_empty = (rq_cnt_ff == '0);
   assign rq_pop    = rsp_pop & ~rsp_empty;

   // a frame end word waits until the result buffer has room
   assign q_pop   = ~q_empty & (~q_word.eof | ~rq_full);
   assign rq_push = q_pop & q_word.eof;

   // box update for the popped word
   always_comb begin
      n_lc  = lc_ff;
      n_gc  = gc_ff;
      n_lr  = lr_ff;
      n_gr  = gr_ff;
      n_any = any_ff;
      if (q_word.match) begin
         if (!any_ff) begin
            n_lc  = q_word.col;
            n_gc  = q_word.col;
            n_lr  = q_word.row;
            n_gr  = q_word.row;
            n_any = 1'b1;
         end else begin
            if (q_word.col < lc_ff) n_lc = q_word.col;
            if (q_word.col > gc_ff) n_gc = q_word.col;
            if (q_word.row < lr_ff) n_lr = q_word.row;
            if (q_word.row > gr_ff) n_gr = q_word.row;
         end
      end
   end

   always_comb begin
      box = '0;
      if (n_any) begin
         box.found  = 1'b1;
         box.left   = n_lc;
         box.top    = n_lr;
         box.width  = SIZE_W'(n_gc) - SIZE_W'(n_lc) + SIZE_W'(1);
         box.height = SIZE_W'(n_gr) - SIZE_W'(n_lr) + SIZE_W'(1);
      end
   end

   always_comb begin
      lc_in  = lc_ff;
      gc_in  = gc_ff;
      lr_in  = lr_ff;
      gr_in  = gr_ff;
      any_in = any_ff;
      if (q_pop) begin
         if (q_word.eof) begin
            lc_in  = '0;
            gc_in  = '0;
            lr_in  = '0;
            gr_in  = '0;
            any_in = 1'b0;
         end else begin
            lc_in  = n_lc;
            gc_in  = n_gc;
            lr_in  = n_lr;
            gr_in  = n_gr;
            any_in = n_any;
         end
      end
   end

   always_comb begin
      rq_wr_in  = rq_push ? rq_wr_ff + RSP_Q_AW'(1) : rq_wr_ff;
      rq_rd_in  = rq_pop ? rq_rd_ff + RSP_Q_AW'(1) : rq_rd_ff;
      rq_cnt_in = rq_cnt_ff;
      if (rq_push && !rq_pop) rq_cnt_in = rq_cnt_ff + (RSP_Q_AW+1)'(1);
      if (!rq_push && rq_pop) rq_cnt_in = rq_cnt_ff - (RSP_Q_AW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lc_ff     <= '0;
         gc_ff     <= '0;
         lr_ff     <= '0;
         gr_ff     <= '0;
         any_ff    <= 1'b0;
         rq_wr_ff  <= '0;
         rq_rd_ff  <= '0;
         rq_cnt_ff <= '0;
      end else begin
         lc_ff     <= lc_in;
         gc_ff     <= gc_in;
         lr_ff     <= lr_in;
         gr_ff     <= gr_in;
         any_ff    <= any_in;
         rq_wr_ff  <= rq_wr_in;
         rq_rd_ff  <= rq_rd_in;
         rq_cnt_ff <= rq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rq_push) rq[rq_wr_ff] <= box;
   end

   assign rsp_box = rq[rq_rd_ff];

endmodule

[rtl/core/color_threshold_bounding_box.sv]
// ----------------------------------------------------------------------------
// color_threshold_bounding_box
// Result path: a frame's last pixel is written to the pixel queue when it is
//   accepted, then popped by the tracker once the words ahead of it are gone
//   and the result buffer has room, and its box is written to the result buffer.
// Throughput: 1 pixel per cycle unless req_full, set by the box update in the
//   back end; the 4-word pixel queue and 2-word result buffer absorb stalls.
// Reset: synchronous; clears counters, box state and queues, and loads the
//   thresholds with red 150, blue 50, green 50.
// ----------------------------------------------------------------------------
module color_threshold_bounding_box (
   input  logic                           clock,
   input  logic                           reset,
   // pixel input
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [ctbb_pkg::CHAN_W-1:0]    req_blue,
   input  logic [ctbb_pkg::CHAN_W-1:0]    req_green,
   input  logic [ctbb_pkg::CHAN_W-1:0]    req_red,
   input  logic                           req_end_of_line,
   input  logic                           req_end_of_frame,
   // frame result
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic                           rsp_found,
   output logic [ctbb_pkg::POS_W-1:0]     rsp_box_left,
   output logic [ctbb_pkg::POS_W-1:0]     rsp_box_top,
   output logic [ctbb_pkg::SIZE_W-1:0]    rsp_box_width,
   output logic [ctbb_pkg::SIZE_W-1:0]    rsp_box_height,
   // threshold registers
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ctbb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ctbb_pkg::CHAN_W-1:0]    csr_wdata
);
   import ctbb_pkg::*;

   q_ctl_type    front_ctl;
   pix_word_type front_word;
   pix_word_type back_word;
   logic         pq_full, pq_empty, pq_pop;
   box_type      box;

   // registers always take a write word; the index decode drops unknown ones
   assign csr_ready = 1'b1;

   // front: raster position and threshold test, one pixel per cycle while the pixel queue is not full
   ctbb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_blue         (req_blue),
      .req_green        (req_green),
      .req_red          (req_red),
      .req_end_of_line  (req_end_of_line),
      .req_end_of_frame (req_end_of_frame),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .q_full           (pq_full),
      .q_ctl            (front_ctl),
      .q_word           (front_word)
   );

   // decouples the pixel side from result back-pressure
   ctbb_pix_queue u_pix_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_ctl  (front_ctl),
      .wr_word (front_word),
      .full    (pq_full),
      .pop     (pq_pop),
      .empty   (pq_empty),
      .rd_word (back_word)
   );

   // back: min/max tracking and result buffer
   ctbb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (pq_empty),
      .q_word    (back_word),
      .q_pop     (pq_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_box   (box)
   );

   assign req_full       = pq_full;
   assign rsp_found      = box.found;
   assign rsp_box_left   = box.left;
   assign rsp_box_top    = box.top;
   assign rsp_box_width  = box.width;
   assign rsp_box_height = box.height;

endmodule
